@@ design/pbl_pkg.sv @@
// shared types, register and style codes, and the floor divide by 255
// used by every module of the pixel blend core; no dependencies
package pbl_pkg;

  localparam int ChanN = 3;

  typedef logic [7:0] chan_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_STYLE    = 3'd0;
  localparam logic [2:0] REG_ALPHA    = 3'd1;
  localparam logic [2:0] REG_TINT_R   = 3'd2;
  localparam logic [2:0] REG_TINT_G   = 3'd3;
  localparam logic [2:0] REG_TINT_B   = 3'd4;
  localparam logic [2:0] REG_STRENGTH = 3'd5;

  // blend style codes
  localparam logic [2:0] BLEND_COPY       = 3'd0;
  localparam logic [2:0] BLEND_TRANSLUC   = 3'd1;
  localparam logic [2:0] BLEND_ADD        = 3'd2;
  localparam logic [2:0] BLEND_SUB        = 3'd3;
  localparam logic [2:0] BLEND_REVSUB     = 3'd4;
  localparam logic [2:0] BLEND_MODULATE   = 3'd5;
  localparam logic [2:0] BLEND_COPY_ALPHA = 3'd6;

  localparam logic [8:0] FULL_OPACITY = 9'd256;
  localparam logic [7:0] CHAN_MAX     = 8'd255;

  typedef struct packed {
    logic [2:0]             style;
    logic [8:0]             alpha;
    logic [ChanN-1:0][7:0]  tint;
    logic [7:0]             strength;
  } cfg_t;

  // source alpha and destination pixel riding along the pipeline
  typedef struct packed {
    logic [7:0]       sa;
    logic [3:0][7:0]  dst;
  } side_t;

  // floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = {1'b0, x} + 17'd1;
    y = y + {8'd0, y[16:8]};
    return y[15:8];
  endfunction

endpackage

@@ design/patch_pixel_blend_core.sv @@
// top level of the patch pixel blend core
// depends on pbl_pkg, pbl_regs, pbl_tint, pbl_mix
//
// pixel compositor: tints a source rgba pixel and blends it into a destination
// pixel with one of seven styles (copy, translucent, add, subtract, reverse
// subtract, modulate, copy alpha). busy is tied low, so a pixel beat is taken
// on every cycle that start is high; each beat yields exactly one result beat
// at the output register, flagged by a one-cycle out_valid. the receiver has
// no way to hold results off and must take every beat as it appears. the four
// stages are: tint products, tint divide-by-255 and sum, blend products, blend
// combine and output register; each stage holds up to two multiplies or two
// divide-by-255 per channel. configuration registers (apb, byte address
// 4*index) are meant to change only while no beat is in flight.
module patch_pixel_blend_core (
  input  logic         clk,
  input  logic         rst_n,
  // pixel input channel
  input  logic         start,
  output logic         busy,
  input  logic [7:0]   in_src_red,
  input  logic [7:0]   in_src_green,
  input  logic [7:0]   in_src_blue,
  input  logic [7:0]   in_src_alpha,
  input  logic [7:0]   in_dst_red,
  input  logic [7:0]   in_dst_green,
  input  logic [7:0]   in_dst_blue,
  input  logic [7:0]   in_dst_alpha,
  // result channel
  output logic         out_valid,
  output logic [7:0]   out_red,
  output logic [7:0]   out_green,
  output logic [7:0]   out_blue,
  output logic [7:0]   out_alpha,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pbl_pkg::*;

  cfg_t                   cfg;
  logic                   in_vld;
  logic [ChanN-1:0][7:0]  src;
  side_t                  side_in, side_t2m;
  logic                   vld_t2m;
  logic [ChanN-1:0][7:0]  src_t2m;
  logic [3:0][7:0]        pix;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  assign src         = {in_src_blue, in_src_green, in_src_red};
  assign side_in.sa  = in_src_alpha;
  assign side_in.dst = {in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red};

  pbl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stages 1-2: tinted source color
  pbl_tint u_tint (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_vld   (in_vld),
    .in_src   (src),
    .in_side  (side_in),
    .out_vld  (vld_t2m),
    .out_src  (src_t2m),
    .out_side (side_t2m)
  );

  // stages 3-4: blend into destination, registered result
  pbl_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_vld  (vld_t2m),
    .in_src  (src_t2m),
    .in_side (side_t2m),
    .out_vld (out_valid),
    .out_pix (pix)
  );

  assign out_red   = pix[0];
  assign out_green = pix[1];
  assign out_blue  = pix[2];
  assign out_alpha = pix[3];

endmodule

@@ design/pbl_regs.sv @@
// configuration registers behind the apb-style port
// depends on pbl_pkg
module pbl_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pbl_pkg::cfg_t cfg
);
  import pbl_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.style    <= BLEND_COPY;
      cfg_r.alpha    <= FULL_OPACITY;
      cfg_r.tint     <= '0;
      cfg_r.strength <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_STYLE:    cfg_r.style    <= pwdata[2:0];
        REG_ALPHA:    cfg_r.alpha    <= pwdata[8:0];
        REG_TINT_R:   cfg_r.tint[0]  <= pwdata[7:0];
        REG_TINT_G:   cfg_r.tint[1]  <= pwdata[7:0];
        REG_TINT_B:   cfg_r.tint[2]  <= pwdata[7:0];
        REG_STRENGTH: cfg_r.strength <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STYLE:    prdata = {29'd0, cfg_r.style};
      REG_ALPHA:    prdata = {23'd0, cfg_r.alpha};
      REG_TINT_R:   prdata = {24'd0, cfg_r.tint[0]};
      REG_TINT_G:   prdata = {24'd0, cfg_r.tint[1]};
      REG_TINT_B:   prdata = {24'd0, cfg_r.tint[2]};
      REG_STRENGTH: prdata = {24'd0, cfg_r.strength};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

@@ design/pbl_tint.sv @@
// tint stages: products in the first stage, divide by 255 and sum in the second
// depends on pbl_pkg
module pbl_tint (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbl_pkg::cfg_t                     cfg,
  input  logic                              in_vld,
  input  logic [pbl_pkg::ChanN-1:0][7:0]    in_src,
  input  pbl_pkg::side_t                    in_side,
  output logic                              out_vld,
  output logic [pbl_pkg::ChanN-1:0][7:0]    out_src,
  output pbl_pkg::side_t                    out_side
);
  import pbl_pkg::*;

  logic                         full_s, zero_s;
  logic [7:0]                   fac;
  logic                         a_vld_r, b_vld_r;
  logic [ChanN-1:0][15:0]       pa_r, pb_r, pa_nxt, pb_nxt;
  logic [ChanN-1:0][7:0]        s_r, s_nxt;
  side_t                        a_side_r, b_side_r;

  assign full_s = (cfg.strength == CHAN_MAX);
  assign zero_s = (cfg.strength == 8'd0);

  // no tint is folded in as c*255/255
  always_comb begin
    for (int i = 0; i < ChanN; i++) begin
      fac       = zero_s ? CHAN_MAX : (full_s ? cfg.tint[i] : CHAN_MAX - cfg.strength);
      pa_nxt[i] = in_src[i] * fac;
      pb_nxt[i] = full_s ? 16'd0 : cfg.tint[i] * cfg.strength;
    end
  end

  always_comb begin
    for (int i = 0; i < ChanN; i++) begin
      s_nxt[i] = div255(pa_r[i]) + div255(pb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    a_side_r <= in_side;
    s_r      <= s_nxt;
    b_side_r <= a_side_r;
  end

  assign out_vld  = b_vld_r;
  assign out_src  = s_r;
  assign out_side = b_side_r;

endmodule

@@ design/pbl_mix.sv @@
// blend stages: weighted products, then combine, clamp and select by style
// depends on pbl_pkg
module pbl_mix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbl_pkg::cfg_t                     cfg,
  input  logic                              in_vld,
  input  logic [pbl_pkg::ChanN-1:0][7:0]    in_src,
  input  pbl_pkg::side_t                    in_side,
  output logic                              out_vld,
  output logic [3:0][7:0]                   out_pix
);
  import pbl_pkg::*;

  logic [8:0]              a_eff;
  logic [8:0]              wd, ws;
  logic                    c_vld_r, d_vld_r;
  logic [ChanN-1:0][15:0]  pd_r, ps_r, pd_nxt, ps_nxt;
  logic [ChanN-1:0][7:0]   s_r;
  side_t                   c_side_r;
  logic                    pass;
  logic [3:0][7:0]         pix_r, pix_nxt;
  logic [16:0]             sum;
  logic [7:0]              scaled, d, s;
  logic [8:0]              dsum;

  assign a_eff = (cfg.alpha > FULL_OPACITY) ? FULL_OPACITY : cfg.alpha;

  // stage c: destination and source weights per style
  always_comb begin
    for (int i = 0; i < ChanN; i++) begin
      case (cfg.style)
        BLEND_TRANSLUC: begin
          wd = FULL_OPACITY - a_eff;
          ws = a_eff;
        end
        BLEND_MODULATE: begin
          wd = 9'd0;
          ws = {1'b0, in_side.dst[i]};
        end
        BLEND_COPY_ALPHA: begin
          wd = {1'b0, CHAN_MAX - in_side.sa};
          ws = {1'b0, in_side.sa};
        end
        default: begin
          wd = 9'd0;
          ws = a_eff;
        end
      endcase
      pd_nxt[i] = 16'(in_side.dst[i] * wd);
      ps_nxt[i] = 16'(in_src[i] * ws);
    end
  end

  // stage d: combine per style; transparent source or unused style keeps dst
  always_comb begin
    pass       = (c_side_r.sa == 8'd0) || (cfg.style > BLEND_COPY_ALPHA);
    pix_nxt[3] = pass ? c_side_r.dst[3] : c_side_r.sa;
    for (int i = 0; i < ChanN; i++) begin
      d      = c_side_r.dst[i];
      s      = s_r[i];
      sum    = {1'b0, pd_r[i]} + {1'b0, ps_r[i]};
      scaled = ps_r[i][15:8];
      dsum   = {1'b0, d} + {1'b0, scaled};
      case (cfg.style)
        BLEND_COPY:       pix_nxt[i] = s;
        BLEND_TRANSLUC:   pix_nxt[i] = sum[15:8];
        BLEND_ADD:        pix_nxt[i] = dsum[8] ? CHAN_MAX : dsum[7:0];
        BLEND_SUB:        pix_nxt[i] = (d > scaled) ? d - scaled : 8'd0;
        BLEND_REVSUB:     pix_nxt[i] = (scaled > d) ? scaled - d : 8'd0;
        BLEND_MODULATE:   pix_nxt[i] = div255(ps_r[i]);
        BLEND_COPY_ALPHA: pix_nxt[i] = (c_side_r.sa == CHAN_MAX) ? s : div255(sum[15:0]);
        default:          pix_nxt[i] = d;
      endcase
      if (pass) begin
        pix_nxt[i] = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      c_vld_r <= in_vld;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pd_r     <= pd_nxt;
    ps_r     <= ps_nxt;
    s_r      <= in_src;
    c_side_r <= in_side;
    pix_r    <= pix_nxt;
  end

  assign out_vld = d_vld_r;
  assign out_pix = pix_r;

endmodule

@@ design/pbl_checker.sv @@
// port-level checks for the pixel blend core, bound to the top level
// depends on patch_pixel_blend_core ports only
module pbl_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  logic [7:0]   in_src_red,
  input  logic [7:0]   in_src_green,
  input  logic [7:0]   in_src_blue,
  input  logic [7:0]   in_src_alpha,
  input  logic [7:0]   in_dst_red,
  input  logic [7:0]   in_dst_green,
  input  logic [7:0]   in_dst_blue,
  input  logic [7:0]   in_dst_alpha,
  input  logic         out_valid,
  input  logic [7:0]   out_red,
  input  logic [7:0]   out_green,
  input  logic [7:0]   out_blue,
  input  logic [7:0]   out_alpha,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready
);

  // every accepted beat gives a result beat
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted beat produced no result");

  // no result without an earlier accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted beat");

  // transparent source passes the destination through
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_src_alpha == 8'd0) |-> ##4
      (out_red == $past(in_dst_red, 4) && out_green == $past(in_dst_green, 4) &&
       out_blue == $past(in_dst_blue, 4) && out_alpha == $past(in_dst_alpha, 4)))
    else $error("transparent source altered destination");

  // reset clears the result strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind patch_pixel_blend_core pbl_checker u_pbl_checker (.*);

@@ dv/patch_pixel_blend_core_tb.sv @@
// self-checking testbench for the patch pixel blend core: random and directed
// pixel beats, apb register phases, a predictor of the tint and blend math
// depends on pbl_pkg and the patch_pixel_blend_core rtl
`timescale 1ns / 100ps

module patch_pixel_blend_core_tb;
  import pbl_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 6;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_LIMIT   = 64;
  localparam int          PIPE_SETTLE   = 6;
  localparam int          RAND_PHASES   = 16;
  localparam int          PHASE_BEATS   = 53;
  // style code the block leaves unused; destination must pass through
  localparam logic [2:0]  BLEND_UNUSED  = 3'd7;

  // one pixel beat: index 0 red, 1 green, 2 blue, 3 alpha
  typedef struct packed {
    logic [3:0][7:0] src;
    logic [3:0][7:0] dst;
  } pixel_beat_t;

  typedef logic [3:0][7:0] rgba_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [7:0]   in_src_red = '0;
  logic [7:0]   in_src_green = '0;
  logic [7:0]   in_src_blue = '0;
  logic [7:0]   in_src_alpha = '0;
  logic [7:0]   in_dst_red = '0;
  logic [7:0]   in_dst_green = '0;
  logic [7:0]   in_dst_blue = '0;
  logic [7:0]   in_dst_alpha = '0;
  logic         out_valid;
  logic [7:0]   out_red;
  logic [7:0]   out_green;
  logic [7:0]   out_blue;
  logic [7:0]   out_alpha;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // mirror of the register file as the block should hold it
  logic [2:0]   style_mirror = BLEND_COPY;
  logic [8:0]   alpha_mirror = FULL_OPACITY;
  chan_t        tint_mirror [ChanN] = '{8'd0, 8'd0, 8'd0};
  chan_t        strength_mirror = 8'd0;

  pixel_beat_t  pending_pixels [$];
  rgba_t        expected_pixels [$];
  int           sender_idle_pct = 0;
  logic         beat_taken = 1'b0;
  int           error_count = 0;
  int           cycle_count = 0;

  patch_pixel_blend_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .in_dst_red   (in_dst_red),
    .in_dst_green (in_dst_green),
    .in_dst_blue  (in_dst_blue),
    .in_dst_alpha (in_dst_alpha),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: tint the source channel, then blend it into the destination
  // ---------------------------------------------------------------------------

  // no tint at strength zero, pure multiply at full strength, else a linear
  // mix where each of the two terms is floored on its own
  function automatic chan_t tint_chan(input chan_t c, input chan_t t, input chan_t s);
    int unsigned ci, ti, si;
    ci = c;
    ti = t;
    si = s;
    if (si == 0) return c;
    if (si == 255) return chan_t'(ci * ti / 255);
    return chan_t'(ci * (255 - si) / 255 + ti * si / 255);
  endfunction

  function automatic chan_t mix_chan(input logic [2:0] style, input int unsigned s,
                                     input int unsigned d, input int unsigned a,
                                     input int unsigned sa);
    int unsigned scaled, r;
    scaled = s * a / 256;
    case (style)
      BLEND_COPY:       r = s;
      BLEND_TRANSLUC:   r = (d * (256 - a) + s * a) / 256;
      BLEND_ADD:        r = (d + scaled > 255) ? 255 : d + scaled;
      BLEND_SUB:        r = (d > scaled) ? d - scaled : 0;
      BLEND_REVSUB:     r = (scaled > d) ? scaled - d : 0;
      BLEND_MODULATE:   r = d * s / 255;
      // opaque source is a straight copy, else a /255 weighted mix
      BLEND_COPY_ALPHA: r = (sa == 255) ? s : (d * (255 - sa) + s * sa) / 255;
      default:          r = d;
    endcase
    return chan_t'(r);
  endfunction

  function automatic rgba_t blend_pixel(input pixel_beat_t p);
    rgba_t       res;
    int unsigned a;
    chan_t       tinted;
    res = p.dst;
    // opacity above one counts as fully opaque
    a = (alpha_mirror > FULL_OPACITY) ? FULL_OPACITY : alpha_mirror;
    // transparent source or the unused style leave the destination untouched
    if (p.src[3] != 8'd0 && style_mirror != BLEND_UNUSED) begin
      for (int i = 0; i < ChanN; i++) begin
        tinted = tint_chan(p.src[i], tint_mirror[i], strength_mirror);
        res[i] = mix_chan(style_mirror, tinted, p.dst[i], a, p.src[3]);
      end
      res[3] = p.src[3];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: inputs move on the falling edge; a new beat goes out once the
  // current one was taken, or whenever the bus is free
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pixel_beat_t beat;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        beat = pending_pixels.pop_front();
        start        <= 1'b1;
        in_src_red   <= beat.src[0];
        in_src_green <= beat.src[1];
        in_src_blue  <= beat.src[2];
        in_src_alpha <= beat.src[3];
        in_dst_red   <= beat.dst[0];
        in_dst_green <= beat.dst[1];
        in_dst_blue  <= beat.dst[2];
        in_dst_alpha <= beat.dst[3];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge. the result beat is checked
  // before the new input beat is predicted, since the pipe has latency
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgba_t       want;
    pixel_beat_t seen;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with nothing pending: %0d %0d %0d %0d",
                 out_red, out_green, out_blue, out_alpha);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want[0]) begin
            $error("out_red expected %0d actual %0d", want[0], out_red);
            error_count++;
          end
          if (out_green !== want[1]) begin
            $error("out_green expected %0d actual %0d", want[1], out_green);
            error_count++;
          end
          if (out_blue !== want[2]) begin
            $error("out_blue expected %0d actual %0d", want[2], out_blue);
            error_count++;
          end
          if (out_alpha !== want[3]) begin
            $error("out_alpha expected %0d actual %0d", want[3], out_alpha);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        seen.src = {in_src_alpha, in_src_blue, in_src_green, in_src_red};
        seen.dst = {in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red};
        expected_pixels.push_back(blend_pixel(seen));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("patch_pixel_blend_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // channel value with the two extremes well represented
  function automatic chan_t rand_chan();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return chan_t'($urandom_range(255));
  endfunction

  // apb write: setup cycle, then access until pready, then back to idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STYLE:    style_mirror    = value[2:0];
      REG_ALPHA:    alpha_mirror    = value[8:0];
      REG_TINT_R:   tint_mirror[0]  = value[7:0];
      REG_TINT_G:   tint_mirror[1]  = value[7:0];
      REG_TINT_B:   tint_mirror[2]  = value[7:0];
      REG_STRENGTH: strength_mirror = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] style, input logic [8:0] alpha,
                            input chan_t strength);
    write_reg(REG_STYLE, {29'd0, style});
    write_reg(REG_ALPHA, {23'd0, alpha});
    write_reg(REG_TINT_R, {24'd0, rand_chan()});
    write_reg(REG_TINT_G, {24'd0, rand_chan()});
    write_reg(REG_TINT_B, {24'd0, rand_chan()});
    write_reg(REG_STRENGTH, {24'd0, strength});
  endtask

  // wait until every queued beat has been taken and every result has come
  // back; a result that never shows up is an error. then let the pipe settle
  // before any register moves
  task automatic drain_pipe();
    int waited;
    waited = 0;
    while (pending_pixels.size() > 0 || start) @(posedge clk);
    while (expected_pixels.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() > 0) begin
      $error("%0d result beats never arrived", expected_pixels.size());
      error_count++;
      expected_pixels.delete();
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pixel_beat_t beat;
    logic [8:0]  alpha_pick;
    chan_t       strength_pick;
    int          idle_plan [4];
    idle_plan = '{0, 79, 0, 17};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: one short burst per style code, the unused one included, with
    // opacity and tint strength walking through their extremes
    for (int s = 0; s < 8; s++) begin
      case (s % 4)
        0: alpha_pick = FULL_OPACITY;
        1: alpha_pick = 9'd0;
        2: alpha_pick = 9'd511;
        default: alpha_pick = 9'd100;
      endcase
      case (s % 3)
        0: strength_pick = 8'd0;
        1: strength_pick = CHAN_MAX;
        default: strength_pick = 8'd77;
      endcase
      set_config(s[2:0], alpha_pick, strength_pick);
      // opaque white onto cleared black
      beat.src = {4{8'd255}};
      beat.dst = '0;
      pending_pixels.push_back(beat);
      // transparent source: destination passes through
      beat.src = {8'd0, rand_chan(), rand_chan(), rand_chan()};
      beat.dst = {4{8'd255}};
      pending_pixels.push_back(beat);
      // partial alpha, mixed content
      beat.src = {chan_t'($urandom_range(1, 254)), rand_chan(), rand_chan(), rand_chan()};
      beat.dst = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
      pending_pixels.push_back(beat);
      drain_pipe();
    end

    // random phases: every style twice; opacity cycles full, zero, out-of-range and
    // partial, strength zero, full and partial; sender gaps varying per phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ((p / 2) % 4)
        0: alpha_pick = FULL_OPACITY;
        1: alpha_pick = 9'd0;
        2: alpha_pick = 9'($urandom_range(257, 511));
        default: alpha_pick = 9'($urandom_range(1, 255));
      endcase
      case (p % 3)
        0: strength_pick = 8'd0;
        1: strength_pick = CHAN_MAX;
        default: strength_pick = chan_t'($urandom_range(1, 254));
      endcase
      set_config(p[2:0], alpha_pick, strength_pick);
      sender_idle_pct = idle_plan[p % 4];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        beat.src = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        beat.dst = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        pending_pixels.push_back(beat);
      end
      drain_pipe();
    end

    if (error_count == 0) begin
      $display("patch_pixel_blend_core verification clean");
    end else begin
      $display("patch_pixel_blend_core verification failed");
    end
    $finish;
  end

endmodule
